// ----- sv/wie_pkg.sv -----
// ----------------------------------------------------------------------------
// wie_pkg: shared types and constants of the 802.11 element PHY-mode scanner
// Element ids, OUI filter values, verdict codes and the payload structs.
// ----------------------------------------------------------------------------
package wie_pkg;

  localparam int unsigned WIE_QUEUE_DEPTH = 4;

  // Element framing phase of the parser
  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } wie_phase_e;

  localparam logic [7:0] ID_ERP     = 8'd42;
  localparam logic [7:0] ID_HT_CAP  = 8'd45;
  localparam logic [7:0] ID_HT_INFO = 8'd61;
  localparam logic [7:0] ID_VENDOR  = 8'd221;

  localparam logic [23:0] OUI_SKIP_A = 24'h0050f2;
  localparam logic [23:0] OUI_SKIP_B = 24'h00904c;

  // Body index saturates at the vendor minimum; only the first three bytes form the OUI
  localparam logic [2:0] OUI_BYTES    = 3'd3;
  localparam logic [2:0] OUI_BODY_MIN = 3'd4;

  localparam logic [15:0] FREQ_SPLIT = 16'd3000;
  localparam logic [31:0] RATE_SPLIT = 32'd24000000;

  localparam logic [1:0] PHY_11A = 2'd0;
  localparam logic [1:0] PHY_11B = 2'd1;
  localparam logic [1:0] PHY_11G = 2'd2;
  localparam logic [1:0] PHY_11N = 2'd3;

  localparam logic KIND_OUI     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0]  ie_byte;
    logic        byte_valid;
    logic        last_byte;
    logic [15:0] freq_mhz;
    logic [31:0] top_rate_bps;
  } wie_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [23:0] vendor_oui;
    logic [1:0]  phy_code;
    logic        from_elements;
    logic        last_result;
  } wie_out_t;

  // Work handed from the parser to the emitter: one or two results
  typedef struct packed {
    logic        has_oui;
    logic [23:0] oui;
    logic        has_verdict;
    logic [1:0]  phy_code;
    logic        from_elements;
  } wie_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } wie_q_stat_t;

  typedef struct packed {
    logic pop;
    logic pend;
  } wie_back_stat_t;

endpackage

// ----- sv/wie_parser.sv -----
// ----------------------------------------------------------------------------
// wie_parser: element list front end
// Follows type/length/body framing one byte per request, tracks ERP and HT
// flags and turns each request into a job when it yields any result.
// ----------------------------------------------------------------------------
module wie_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wie_pkg::wie_in_t    in_data_i,
  input  wie_pkg::wie_q_stat_t q_stat_i,
  output logic                job_valid_o,
  output wie_pkg::wie_job_t   job_o
);
  import wie_pkg::*;

  wie_phase_e  phase_q, phase_d;
  logic [7:0]  elem_type_q, elem_type_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [2:0]  body_idx_q, body_idx_d;
  logic [23:0] oui_q, oui_d;
  logic        ht_q, ht_d;
  logic        erp_q, erp_d;

  logic        acc;
  logic        parse;
  logic        finish;
  logic        emit_oui;
  logic [1:0]  mode;
  logic        from_elem;

  assign in_ready_o = !q_stat_i.full;
  assign acc        = in_valid_i && in_ready_o;
  assign parse      = acc && in_data_i.byte_valid;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (parse) begin
      unique case (phase_q)
        PH_LEN:  phase_d = (in_data_i.ie_byte == 8'd0) ? PH_TYPE : PH_BODY;
        PH_BODY: if (bytes_left_q == 8'd1) phase_d = PH_TYPE;
        default: phase_d = PH_LEN;
      endcase
    end
    if (acc && in_data_i.last_byte) phase_d = PH_TYPE;
  end

  // Element datapath and job build
  always_comb begin
    elem_type_d  = elem_type_q;
    bytes_left_d = bytes_left_q;
    body_idx_d   = body_idx_q;
    oui_d        = oui_q;
    ht_d         = ht_q;
    erp_d        = erp_q;
    finish       = 1'b0;
    emit_oui     = 1'b0;
    mode         = PHY_11A;
    from_elem    = 1'b1;

    if (parse) begin
      case (phase_q)
        PH_LEN: begin
          bytes_left_d = in_data_i.ie_byte;
          body_idx_d   = 3'd0;
          oui_d        = 24'd0;
          finish       = (in_data_i.ie_byte == 8'd0);
        end
        PH_BODY: begin
          if (body_idx_q < OUI_BYTES) oui_d = {oui_q[15:0], in_data_i.ie_byte};
          if (body_idx_q < OUI_BODY_MIN) body_idx_d = body_idx_q + 3'd1;
          bytes_left_d = bytes_left_q - 8'd1;
          finish       = (bytes_left_q == 8'd1);
        end
        default: elem_type_d = in_data_i.ie_byte;
      endcase
    end

    if (finish) begin
      if (elem_type_q == ID_ERP) begin
        erp_d = 1'b1;
      end else if (elem_type_q == ID_HT_CAP || elem_type_q == ID_HT_INFO) begin
        ht_d = 1'b1;
      end else if (elem_type_q == ID_VENDOR && body_idx_d >= OUI_BODY_MIN) begin
        emit_oui = (oui_d != OUI_SKIP_A) && (oui_d != OUI_SKIP_B);
      end
    end

    if (ht_d) begin
      mode = PHY_11N;
    end else if (erp_d) begin
      mode = PHY_11G;
    end else begin
      from_elem = 1'b0;
      if (in_data_i.freq_mhz < FREQ_SPLIT) begin
        mode = (in_data_i.top_rate_bps < RATE_SPLIT) ? PHY_11B : PHY_11G;
      end else begin
        mode = PHY_11A;
      end
    end

    job_o.has_oui       = emit_oui;
    job_o.oui           = oui_d;
    job_o.has_verdict   = in_data_i.last_byte;
    job_o.phy_code      = mode;
    job_o.from_elements = from_elem;
    job_valid_o         = acc && (emit_oui || in_data_i.last_byte);

    // End of list: start the next one from scratch
    if (acc && in_data_i.last_byte) begin
      elem_type_d  = 8'd0;
      bytes_left_d = 8'd0;
      body_idx_d   = 3'd0;
      oui_d        = 24'd0;
      ht_d         = 1'b0;
      erp_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TYPE;
      elem_type_q  <= 8'd0;
      bytes_left_q <= 8'd0;
      body_idx_q   <= 3'd0;
      oui_q        <= 24'd0;
      ht_q         <= 1'b0;
      erp_q        <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      elem_type_q  <= elem_type_d;
      bytes_left_q <= bytes_left_d;
      body_idx_q   <= body_idx_d;
      oui_q        <= oui_d;
      ht_q         <= ht_d;
      erp_q        <= erp_d;
    end
  end

endmodule

// ----- sv/wie_queue.sv -----
// ----------------------------------------------------------------------------
// wie_queue: job queue between parser and emitter
// Small register FIFO so that each side can stall on its own.
// ----------------------------------------------------------------------------
module wie_queue #(
  parameter int unsigned Depth = wie_pkg::WIE_QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  wie_pkg::wie_job_t    push_data_i,
  input  logic                 pop_i,
  output wie_pkg::wie_job_t    head_o,
  output wie_pkg::wie_q_stat_t stat_o
);
  import wie_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  wie_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntFull);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- sv/wie_emitter.sv -----
// ----------------------------------------------------------------------------
// wie_emitter: result back end
// Pops jobs and drives the registered result port; a job with an OUI report
// and a verdict holds the verdict back for the following slot.
// ----------------------------------------------------------------------------
module wie_emitter (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wie_pkg::wie_job_t       job_i,
  input  wie_pkg::wie_q_stat_t    q_stat_i,
  output wie_pkg::wie_back_stat_t stat_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output wie_pkg::wie_out_t       out_data_o
);
  import wie_pkg::*;

  logic     out_valid_q, out_valid_d;
  wie_out_t out_q, out_d;
  logic     pend_q, pend_d;
  wie_out_t vrd_q, vrd_d;
  wie_out_t job_oui;
  wie_out_t job_vrd;
  logic     load;

  assign load        = !out_valid_q || out_ready_i;
  assign stat_o.pop  = load && !pend_q && !q_stat_i.empty;
  assign stat_o.pend = pend_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    job_oui.result_kind   = KIND_OUI;
    job_oui.vendor_oui    = job_i.oui;
    job_oui.phy_code      = PHY_11A;
    job_oui.from_elements = 1'b0;
    job_oui.last_result   = 1'b0;

    job_vrd.result_kind   = KIND_VERDICT;
    job_vrd.vendor_oui    = 24'd0;
    job_vrd.phy_code      = job_i.phy_code;
    job_vrd.from_elements = job_i.from_elements;
    job_vrd.last_result   = 1'b1;
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pend_d      = pend_q;
    vrd_d       = vrd_q;
    if (load) begin
      if (pend_q) begin
        out_d       = vrd_q;
        out_valid_d = 1'b1;
        pend_d      = 1'b0;
      end else if (!q_stat_i.empty) begin
        out_valid_d = 1'b1;
        if (job_i.has_oui) begin
          out_d  = job_oui;
          pend_d = job_i.has_verdict;
          vrd_d  = job_vrd;
        end else begin
          out_d = job_vrd;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    vrd_q <= vrd_d;
  end

endmodule

// ----- sv/wifi_ie_phy_mode_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// wifi_ie_phy_mode_scanner_unit: 802.11 element list PHY-mode scanner
// Parses information elements byte by byte, reports vendor OUIs and gives
// the PHY mode at the end of each list.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | in_data_i  (wie_in_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (wie_out_t)
//
// One byte is accepted per cycle while the job queue is not full; the parser
// state updates in the cycle the byte is taken. A result shows at the output
// register at the edge that pops its job from the job queue. A byte that ends
// a vendor element with a reported OUI and is the last byte of a list yields
// two results and takes two output slots. Output stalls back up into the job
// queue (QueueDepth jobs) then drop in_ready_o. Reset clears all parse state at once.
// ----------------------------------------------------------------------------
module wifi_ie_phy_mode_scanner_unit #(
  parameter int unsigned QueueDepth = wie_pkg::WIE_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wie_pkg::wie_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wie_pkg::wie_out_t out_data_o
);
  import wie_pkg::*;

  logic           job_valid;
  wie_job_t       job;
  wie_job_t       head;
  wie_q_stat_t    q_stat;
  wie_back_stat_t back_stat;

  wie_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_stat_i    (q_stat),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  wie_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_valid),
    .push_data_i (job),
    .pop_i       (back_stat.pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  wie_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head),
    .q_stat_i    (q_stat),
    .stat_o      (back_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Every accepted end of list must leave a verdict job behind
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.last_byte) |-> job_valid)
    else $error("end of list accepted without a queued job");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |-> !q_stat.empty)
    else $error("job queue popped while empty");

  // A held verdict only ever sits behind a shown OUI report
  a_pend_behind_oui: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pend |-> (out_valid_o && out_data_o.result_kind == KIND_OUI))
    else $error("verdict held without an OUI report in front");

endmodule
